// ===== sv/tdf_pkg.sv =====
// shared types and constants for the trial division factorizer
package tdf_pkg;

  // default operand width and the cap on results per input
  localparam int TDF_WIDTH       = 32;
  localparam int TDF_MAX_RESULTS = 32;
  localparam int TDF_CNT_W       = $clog2(TDF_MAX_RESULTS);

  // result status codes
  typedef enum logic [1:0] {
    STATUS_FACTOR = 2'd0,
    STATUS_SMALL  = 2'd1,
    STATUS_PRIME  = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture input value, reset divisor and count
    logic div_start;  // begin a division of the next n by the next d
    logic next_d;     // step the trial divisor
    logic take_q;     // replace n by the quotient, bump the count
    logic emit_fac;   // load the divisor as a non-final factor
    logic emit_end;   // load the final result of the run
  } tdf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic below_two;  // n below two
    logic busy;       // divider still iterating
    logic d_gt_q;     // d exceeds n / d, so what remains is prime
    logic rem_zero;   // d divides n
    logic count_full; // only room left for the final result
    logic count_zero; // no factor split off yet
    logic out_free;   // output register can take a beat this cycle
  } tdf_sts_t;

endpackage

// ===== sv/tdf_if.sv =====
// valid/ready channel interfaces for the input and result sides

interface tdf_in_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdf_out_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] factor;
  logic             last;
  logic [1:0]       status;

  modport source (output valid, output factor, output last, output status, input ready);
  modport sink   (input valid, input factor, input last, input status, output ready);
endinterface

// ===== sv/tdf_ctrl.sv =====
// control state machine for the trial division factorizer
module tdf_ctrl
  import tdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tdf_sts_t sts,
  output tdf_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_CHECK    = 5'b00010,
    ST_DIV      = 5'b00100,
    ST_EMIT_FAC = 5'b01000,
    ST_EMIT_END = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.below_two) begin
          state_nxt = ST_EMIT_END;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        // decide once the quotient and remainder have settled
        if (!sts.busy) begin
          priority if (sts.d_gt_q) begin
            state_nxt = ST_EMIT_END;
          end else if (sts.rem_zero) begin
            state_nxt = sts.count_full ? ST_EMIT_END : ST_EMIT_FAC;
          end else begin
            cmd.next_d    = 1'b1;
            cmd.div_start = 1'b1;
          end
        end
      end
      ST_EMIT_FAC: begin
        if (sts.out_free) begin
          cmd.emit_fac  = 1'b1;
          cmd.take_q    = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_EMIT_END: begin
        if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/tdf_dpath.sv =====
// datapath: remaining value, trial divisor, bit-serial divider, output register
module tdf_dpath
  import tdf_pkg::*;
#(
  parameter int WIDTH = TDF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIDTH-1:0] in_value,
  input  tdf_cmd_t         cmd,
  output tdf_sts_t         sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_factor,
  output logic             out_last,
  output logic [1:0]       out_status
);

  localparam int DCNT_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]     n_r, n_nxt;
  logic [WIDTH-1:0]     d_r, d_nxt;
  logic [TDF_CNT_W-1:0] count_r, count_nxt;
  logic [WIDTH-1:0]     quo_r, quo_nxt;
  logic [WIDTH-1:0]     rem_r, rem_nxt;
  logic [DCNT_W-1:0]    dcnt_r, dcnt_nxt;
  logic [WIDTH:0]       rem_sh;
  logic [WIDTH:0]       diff;
  logic                 ge;
  logic                 busy;

  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] factor_r, factor_nxt;
  logic             last_r, last_nxt;
  status_t          status_r, status_nxt;

  // remaining value, trial divisor and result count
  always_comb begin
    n_nxt     = n_r;
    d_nxt     = d_r;
    count_nxt = count_r;
    if (cmd.load) begin
      n_nxt     = in_value;
      d_nxt     = WIDTH'(2);
      count_nxt = '0;
    end
    if (cmd.take_q) begin
      n_nxt     = quo_r;
      count_nxt = count_r + TDF_CNT_W'(1);
    end
    if (cmd.next_d) begin
      d_nxt = d_r + WIDTH'(1);
    end
  end

  // restoring divider, one quotient bit a cycle, divisor read live from d_r
  assign busy   = (dcnt_r != '0);
  assign rem_sh = {rem_r, quo_r[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, d_r};
  assign ge     = (rem_sh >= {1'b0, d_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dcnt_nxt = dcnt_r;
    if (cmd.div_start) begin
      quo_nxt  = n_nxt;
      rem_nxt  = '0;
      dcnt_nxt = DCNT_W'(WIDTH);
    end else if (busy) begin
      quo_nxt  = {quo_r[WIDTH-2:0], ge};
      rem_nxt  = ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      dcnt_nxt = dcnt_r - DCNT_W'(1);
    end
  end

  // output register, refilled in the cycle its beat leaves
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    factor_nxt    = factor_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    if (cmd.emit_fac) begin
      out_valid_nxt = 1'b1;
      factor_nxt    = d_r;
      last_nxt      = 1'b0;
      status_nxt    = STATUS_FACTOR;
    end else if (cmd.emit_end) begin
      out_valid_nxt = 1'b1;
      last_nxt      = 1'b1;
      priority if (sts.below_two) begin
        factor_nxt = '0;
        status_nxt = STATUS_SMALL;
      end else if (sts.count_zero) begin
        factor_nxt = n_r;
        status_nxt = STATUS_PRIME;
      end else begin
        factor_nxt = n_r;
        status_nxt = STATUS_FACTOR;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts.below_two  = (n_r < WIDTH'(2));
    sts.busy       = busy;
    sts.d_gt_q     = (d_r > quo_r);
    sts.rem_zero   = (rem_r == '0);
    sts.count_full = (count_r == TDF_CNT_W'(TDF_MAX_RESULTS - 1));
    sts.count_zero = (count_r == '0);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    d_r      <= d_nxt;
    count_r  <= count_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    factor_r <= factor_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_factor = factor_r;
  assign out_last   = last_r;
  assign out_status = status_r;

endmodule

// ===== sv/trial_division_factorizer.sv =====
// Trial division prime factorizer: one input value, a run of factor beats.
// Each trial divisor is tried with one bit-serial division of what remains, and each
// factor found costs one more division by the same divisor.
// Worst case at WIDTH 32 is a prime near 2^32: about 65535 trials.
// One value at a time; a new value is taken while the last beat still waits.
// Synchronous active-low reset clears the controller and the valid flags.
module trial_division_factorizer
  import tdf_pkg::*;
#(
  parameter int WIDTH = TDF_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  tdf_in_if.sink    in_ch,
  tdf_out_if.source out_ch
);

  tdf_cmd_t cmd;
  tdf_sts_t sts;

  // sequencing
  tdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and result register
  tdf_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_ch.value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_factor (out_ch.factor),
    .out_last   (out_ch.last),
    .out_status (out_ch.status)
  );

endmodule

// ===== sv/tdf_checker.sv =====
// port-level checks for the trial division factorizer, bound to the top level
module tdf_checker
  import tdf_pkg::*;
#(
  parameter int WIDTH = TDF_WIDTH
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] out_factor,
  input logic             out_last,
  input logic [1:0]       out_status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_factor)
      && $stable(out_last) && $stable(out_status))
    else $error("result beat changed while stalled");

  // one value at a time: input closes after a beat is taken
  a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a value is in progress");

  // too-small status is a final beat with a zero factor
  a_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_SMALL |-> out_last && out_factor == '0)
    else $error("too-small result malformed");

  // prime status only on a final beat with a factor of at least two
  a_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_PRIME |-> out_last && out_factor >= WIDTH'(2))
    else $error("prime result malformed");

  // non-final beats are real factors
  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == STATUS_FACTOR && out_factor >= WIDTH'(2))
    else $error("non-final beat malformed");

endmodule

bind trial_division_factorizer tdf_checker #(
  .WIDTH (WIDTH)
) u_tdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_factor (out_ch.factor),
  .out_last   (out_ch.last),
  .out_status (out_ch.status)
);

// ===== test/tb_top.sv =====
// self-checking testbench for the trial division factorizer: directed table, then random values
module tb_top;
  import tdf_pkg::*;

  localparam int W               = TDF_WIDTH;
  localparam int DIR_ROWS        = 20;
  localparam int N_RANDOM        = 74;
  localparam int N_PRESSURE      = 6;
  localparam int HOLDOFF_CYCLES  = 2000;
  localparam int RAND_TRIAL_CAP  = 600;
  localparam int NO_CAP          = 1 << 20;
  localparam int END_SETTLE      = 100;
  localparam int WATCHDOG_LIMIT  = 150000;

  // one result beat as the block should present it
  typedef struct packed {
    logic [W-1:0] factor;
    logic         last;
    status_t      status;
  } beat_t;

  // directed row: n_fixed of zero means the run comes from the predictor
  typedef struct packed {
    logic [W-1:0]      value;
    logic [2:0]        n_fixed;
    status_t           fixed_status;
    logic [0:4][W-1:0] fixed;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{32'd0,          3'd1, STATUS_SMALL,  '0},
    '{32'd1,          3'd1, STATUS_SMALL,  '0},
    '{32'd2,          3'd1, STATUS_PRIME,  {32'd2, 128'd0}},
    '{32'd3,          3'd1, STATUS_PRIME,  {32'd3, 128'd0}},
    '{32'd4,          3'd2, STATUS_FACTOR, {32'd2, 32'd2, 96'd0}},
    '{32'd6,          3'd2, STATUS_FACTOR, {32'd2, 32'd3, 96'd0}},
    '{32'd9,          3'd2, STATUS_FACTOR, {32'd3, 32'd3, 96'd0}},
    '{32'd25,         3'd2, STATUS_FACTOR, {32'd5, 32'd5, 96'd0}},
    '{32'hFFFF_FFFF,  3'd5, STATUS_FACTOR, {32'd3, 32'd5, 32'd17, 32'd257, 32'd65537}},
    '{32'd65537,      3'd1, STATUS_PRIME,  {32'd65537, 128'd0}},
    '{32'h8000_0000,  3'd0, STATUS_FACTOR, '0},
    '{32'hAAAA_AAAA,  3'd0, STATUS_FACTOR, '0},
    '{32'd3486784401, 3'd0, STATUS_FACTOR, '0},
    '{32'd4294836225, 3'd0, STATUS_FACTOR, '0},
    '{32'd720720,     3'd0, STATUS_FACTOR, '0},
    '{32'd999983,     3'd0, STATUS_FACTOR, '0},
    '{32'd1052651,    3'd0, STATUS_FACTOR, '0},
    '{32'd16711935,   3'd0, STATUS_FACTOR, '0},
    '{32'd63001,      3'd0, STATUS_FACTOR, '0},
    '{32'd210,        3'd0, STATUS_FACTOR, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  tdf_in_if  #(.WIDTH(W)) in_ch ();
  tdf_out_if #(.WIDTH(W)) out_ch ();

  trial_division_factorizer #(.WIDTH(W)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  beat_t pending_factors [$];
  beat_t run_beats [$];
  beat_t want;
  int    err_count    = 0;
  int    beats_seen   = 0;
  int    n_sent       = 0;
  int    longest_run  = 0;
  int    quiet_cycles = 0;
  bit    tx_gaps_on   = 1'b1;
  bit    rx_stalls_on = 1'b1;
  bit    holdoff_req  = 1'b0;

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    err_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // factor one value into run_beats; returns the last trial divisor,
  // or -1 once the divisor climbs past d_cap
  function automatic int factorize(input logic [W-1:0] value, input int d_cap);
    logic [W-1:0] n;
    logic [W-1:0] d;
    int           count;
    run_beats.delete();
    n     = value;
    d     = 2;
    count = 0;
    if (n < 2) begin
      run_beats.push_back('{factor: '0, last: 1'b1, status: STATUS_SMALL});
      return 0;
    end
    // climb divisors while d*d fits under what remains
    while (d <= n / d) begin
      if (n % d == 0) begin
        if (count == TDF_MAX_RESULTS - 1) break;
        run_beats.push_back('{factor: d, last: 1'b0, status: STATUS_FACTOR});
        count++;
        n = n / d;
      end else begin
        d++;
        if (d > d_cap) return -1;
      end
    end
    // what remains is the final factor
    if (count == 0) run_beats.push_back('{factor: n, last: 1'b1, status: STATUS_PRIME});
    else run_beats.push_back('{factor: n, last: 1'b1, status: STATUS_FACTOR});
    return d;
  endfunction

  // random value whose factoring stays cheap; leaves its run in run_beats
  function automatic logic [W-1:0] pick_value();
    logic [W-1:0] v;
    logic [63:0]  prod;
    int           kind;
    int           r;
    int           f;
    do begin
      kind = $urandom_range(0, 9);
      r    = $urandom_range(0, W - 1);
      case (kind)
        0, 1, 2, 3: v = $urandom >> r;
        4, 5: begin
          // product of small factors, many repeats
          prod = 1;
          repeat ($urandom_range(1, 14)) begin
            f = $urandom_range(2, 40);
            if (prod * f < (64'd1 << W)) prod = prod * f;
          end
          v = prod[W-1:0];
        end
        6: v = $urandom;
        7: begin
          case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 1);
            1: v = '1;
            2: v = W'(1) << r;
            default: v = (W'(1) << r) + 1;
          endcase
        end
        default: v = W'($urandom_range(2, 700)) << r;
      endcase
    end while (factorize(v, RAND_TRIAL_CAP) < 0);
    return v;
  endfunction

  // offer one value, then queue its run once the beat is taken
  task automatic send_value(input logic [W-1:0] value, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    foreach (run_beats[i]) pending_factors.push_back(run_beats[i]);
    if (run_beats.size() > longest_run) longest_run = run_beats.size();
    n_sent++;
  endtask

  // stop offering and wait until every queued factor has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_factors.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // result side ready: random stall bursts plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        stall_left  = HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
      end else if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest queued factor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (pending_factors.size() == 0) begin
        report_mismatch($sformatf("beat with nothing queued: factor %0d last %0b status %0d",
                                  out_ch.factor, out_ch.last, out_ch.status));
      end else begin
        want = pending_factors.pop_front();
        if (out_ch.factor !== want.factor)
          report_mismatch($sformatf("factor %0d, want %0d", out_ch.factor, want.factor));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b (factor %0d)",
                                    out_ch.last, want.last, want.factor));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %s (factor %0d)",
                                    out_ch.status, want.status.name(), want.factor));
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d factors outstanding",
               WATCHDOG_LIMIT, pending_factors.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    dir_row_t     row;
    logic [W-1:0] v;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.n_fixed == 0) begin
        void'(factorize(row.value, NO_CAP));
      end else begin
        run_beats.delete();
        for (int k = 0; k < row.n_fixed; k++)
          run_beats.push_back('{factor: row.fixed[k], last: (k == row.n_fixed - 1),
                                 status: row.fixed_status});
      end
      send_value(row.value, tx_gaps_on);
    end
    drain_results();

    // long result-side hold-off while small values keep coming
    holdoff_req = 1'b1;
    repeat (N_PRESSURE) begin
      v = $urandom_range(2, 64);
      void'(factorize(v, NO_CAP));
      send_value(v, 1'b0);
    end

    // random values, idle settings per stretch, none at the tail
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i >= N_RANDOM - 20) begin
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
      end else if (i % 12 == 0) begin
        tx_gaps_on   = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (i == N_RANDOM / 2) drain_results();
      v = pick_value();
      send_value(v, tx_gaps_on);
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_factors.size() != 0)
      report_mismatch($sformatf("%0d factors never came out", pending_factors.size()));

    $display("covered %0d values (%0d table rows, %0d under hold-off, %0d random)",
             n_sent, DIR_ROWS, N_PRESSURE, N_RANDOM);
    $display("checked %0d factor beats, longest run %0d beats, %0d mismatches",
             beats_seen, longest_run, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tdf_pkg.sv
sv/tdf_if.sv
sv/tdf_ctrl.sv
sv/tdf_dpath.sv
sv/trial_division_factorizer.sv
sv/tdf_checker.sv
test/tb_top.sv
